FILE: hw/rtl/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

	// Frame limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// Position counters: column index, and a row that runs two past the last row
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int W_W   = COL_W + 1;
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

	// Register field widths
	localparam int FW_W = 11;
	localparam int FH_W = 13;

	// Pixel and window geometry
	localparam int CH_W     = 8;
	localparam int N_CH     = 3;
	localparam int PIX_W    = N_CH * CH_W;
	localparam int LINE_W   = 2 * PIX_W;
	localparam int WIN_SIDE = 3;
	localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
	localparam int CNT_W    = $clog2(WIN_N + 1);

	// Register bus
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int IDX_LSB   = 2;
	localparam int REG_IDX_W = ADDR_W - IDX_LSB;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} reg_idx_t;

	// Frame geometry as the datapath sees it
	typedef struct packed {
		logic [W_W-1:0]   w;
		logic [ROW_W-1:0] h;
		logic             restart;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/median_filter_3x3_rgb.sv
// 3x3 per-channel median filter for an RGB pixel stream in raster order.
//
// Input channel (pix_valid / pix_stall): one request per raster position,
// carrying red_in, green_in, blue_in, or drain = 1 to advance the position
// without a pixel. After the width * height pixels of a frame, send
// width + 1 drain requests to flush the last row.
// Result channel (res_valid / res_stall): the median of the in-frame 3x3
// neighbours of one position; frame_done marks the frame's last position,
// after which the next request starts a new frame.
// Register port: frame_width at 0x0, frame_height at 0x4. Any write restarts
// the frame. Write only while no request is in flight.
//
// Throughput: one request per cycle while res_stall is low. The result
// caused by a request passes three registered stages (line-memory read,
// window shift, rank-select median into the result register). The single
// 48-bit line memory is read and written once per request. When res_stall
// is held the three stages fill and pix_stall rises; nothing is lost. Reset
// clears the position and the pipeline valid bits, sets 1024 x 768, and
// leaves the line memory unchanged.
`default_nettype none

module median_filter_3x3_rgb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mf3_pkg::ADDR_W-1:0]  paddr,
	input  logic [mf3_pkg::DATA_W-1:0]  pwdata,
	output logic [mf3_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  logic [mf3_pkg::CH_W-1:0]    red_in,
	input  logic [mf3_pkg::CH_W-1:0]    green_in,
	input  logic [mf3_pkg::CH_W-1:0]    blue_in,
	input  logic                        drain,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [mf3_pkg::CH_W-1:0]    median_red,
	output logic [mf3_pkg::CH_W-1:0]    median_green,
	output logic [mf3_pkg::CH_W-1:0]    median_blue,
	output logic                        frame_done
);
	import mf3_pkg::*;

	cfg_t cfg;

	mf3_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Flow control: each stage moves when the one after it has room
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, res_valid_q;
	logic emit_s1, emit_s2;
	logic out_free, s2_go, s2_free, s1_go, s1_free, accept;

	assign out_free  = !res_valid_q || !res_stall;
	assign s2_go     = valid_s2 && (!emit_s2 || out_free);
	assign s2_free   = !valid_s2 || s2_go;
	assign s1_go     = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s1_go;
	assign pix_stall = !s1_free;
	assign accept    = pix_valid && !pix_stall;

	// ------------------------------------------------------------------
	// Position of the next request and what it will produce
	// ------------------------------------------------------------------
	logic [COL_W-1:0]   col_q, col_a;
	logic [ROW_W-1:0]   row_q, row_a;
	logic [ROW_W:0]     row_x, h_x, hp1_x;
	logic [W_W-1:0]     col_inc;
	logic               guard, emit2, emit1, top_ok, bot_ok, c0_ok, c2_ok;
	logic               done_a, wrap;
	logic [WIN_SIDE-1:0] row_ok, col_ok;
	logic [WIN_N-1:0]   mask_a;
	logic [PIX_W-1:0]   pix_a;

	assign h_x   = {1'b0, cfg.h};
	assign hp1_x = h_x + (ROW_W+1)'(1);

	// Out-of-frame position: start over at the origin
	assign guard = ({1'b0, col_q} >= cfg.w) || ({1'b0, row_q} > hp1_x);
	assign col_a = guard ? '0 : col_q;
	assign row_a = guard ? '0 : row_q;
	assign row_x = {1'b0, row_a};

	// Row start emits the last column of the row two above; any other
	// column emits the previous column of the row above
	assign emit2  = (col_a == '0) && (row_x >= (ROW_W+1)'(2));
	assign emit1  = (col_a != '0) && (row_a != '0);
	assign done_a = emit2 && (row_x == hp1_x);

	assign top_ok = emit2 ? (row_x >= (ROW_W+1)'(3)) : (row_x >= (ROW_W+1)'(2));
	assign bot_ok = emit2 ? (row_x <= h_x) : (row_x < h_x);
	assign c0_ok  = emit2 ? (cfg.w >= W_W'(2)) : ({1'b0, col_a} >= W_W'(2));
	assign c2_ok  = !emit2;

	assign row_ok = {bot_ok, 1'b1, top_ok};
	assign col_ok = {c2_ok, 1'b1, c0_ok};

	// Window mask over the shifted window: the row-start case sees the old
	// middle and right columns, now sitting in the left and middle slots
	always_comb begin
		for (int r = 0; r < WIN_SIDE; r++)
			for (int c = 0; c < WIN_SIDE; c++)
				mask_a[r*WIN_SIDE + c] = row_ok[r] && col_ok[c];
	end

	// Drains and positions below the last row store a zero pixel
	assign pix_a = (drain || (row_x >= h_x)) ? '0 : {red_in, green_in, blue_in};

	assign col_inc = {1'b0, col_a} + W_W'(1);
	assign wrap    = col_inc >= cfg.w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (done_a) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_a + ROW_W'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_a;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line memory read lands here; write back both lines
	// ------------------------------------------------------------------
	logic [LINE_W-1:0]  line_rd, line_s1, byp_data_s1;
	logic               byp_s1, done_s1;
	logic [COL_W-1:0]   col_s1;
	logic [PIX_W-1:0]   pix_s1, top_s1, mid_s1;
	logic [WIN_N-1:0]   mask_s1;

	mf3_line_mem u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_a),
		.rd_data (line_rd),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data ({mid_s1, pix_s1})
	);

	// A write to the address being read in the same cycle is forwarded
	assign line_s1 = byp_s1 ? byp_data_s1 : line_rd;
	assign top_s1  = line_s1[LINE_W-1:PIX_W];
	assign mid_s1  = line_s1[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_a;
			pix_s1      <= pix_a;
			emit_s1     <= emit2 || emit1;
			done_s1     <= done_a;
			mask_s1     <= mask_a;
			byp_s1      <= s1_go && (col_s1 == col_a);
			byp_data_s1 <= {mid_s1, pix_s1};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: shift the window, new right column enters
	// ------------------------------------------------------------------
	logic [WIN_N-1:0][PIX_W-1:0] win_s2;
	logic [WIN_N-1:0]            mask_s2;
	logic                        done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= s1_go;
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int r = 0; r < WIN_SIDE; r++) begin
				win_s2[r*WIN_SIDE]     <= win_s2[r*WIN_SIDE + 1];
				win_s2[r*WIN_SIDE + 1] <= win_s2[r*WIN_SIDE + 2];
			end
			win_s2[WIN_SIDE - 1]     <= top_s1;
			win_s2[2*WIN_SIDE - 1]   <= mid_s1;
			win_s2[WIN_N - 1]        <= pix_s1;
			emit_s2                  <= emit_s1;
			done_s2                  <= done_s1;
			mask_s2                  <= mask_s1;
		end
	end

	// ------------------------------------------------------------------
	// Median per channel into the result register
	// ------------------------------------------------------------------
	logic [N_CH-1:0][WIN_N-1:0][CH_W-1:0] chv;
	logic [N_CH-1:0][CH_W-1:0]            med;
	logic [N_CH-1:0][CH_W-1:0]            med_q;
	logic                                 done_q;

	// Channel 0 is red, held in the top byte
	always_comb begin
		for (int k = 0; k < N_CH; k++)
			for (int i = 0; i < WIN_N; i++)
				chv[k][i] = win_s2[i][(N_CH-1-k)*CH_W +: CH_W];
	end

	for (genvar k = 0; k < N_CH; k++) begin : g_ch
		mf3_median u_med (
			.vals (chv[k]),
			.mask (mask_s2),
			.med  (med[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= s2_go && emit_s2;
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_go && emit_s2) begin
			med_q  <= med;
			done_q <= done_s2;
		end
	end

	assign res_valid    = res_valid_q;
	assign median_red   = med_q[0];
	assign median_green = med_q[1];
	assign median_blue  = med_q[2];
	assign frame_done   = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_cfg.sv
`default_nettype none

module mf3_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mf3_pkg::ADDR_W-1:0]  paddr,
	input  logic [mf3_pkg::DATA_W-1:0]  pwdata,
	output logic [mf3_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output mf3_pkg::cfg_t               cfg
);
	import mf3_pkg::*;

	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	reg_idx_t        idx;
	logic            wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_W'(1024);
			fh_q <= FH_W'(768);
		end else if (wr) begin
			case (idx)
				REG_FRAME_WIDTH:  fw_q <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(fw_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(fh_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp to the supported range: zero acts as one, oversize as the maximum
	always_comb begin
		if (fw_q == '0)
			cfg.w = W_W'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH))
			cfg.w = W_W'(MAX_WIDTH);
		else
			cfg.w = W_W'(fw_q);

		if (fh_q == '0)
			cfg.h = ROW_W'(1);
		else if (32'(fh_q) > 32'(MAX_HEIGHT))
			cfg.h = ROW_W'(MAX_HEIGHT);
		else
			cfg.h = ROW_W'(fh_q);

		cfg.restart = wr;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_line_mem.sv
`default_nettype none

module mf3_line_mem (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [mf3_pkg::COL_W-1:0]   rd_addr,
	output logic [mf3_pkg::LINE_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [mf3_pkg::COL_W-1:0]   wr_addr,
	input  logic [mf3_pkg::LINE_W-1:0]  wr_data
);
	import mf3_pkg::*;

	// Upper line in the high half, lower line in the low half
	logic [LINE_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_median.sv
`default_nettype none

module mf3_median (
	input  logic [mf3_pkg::WIN_N-1:0][mf3_pkg::CH_W-1:0] vals,
	input  logic [mf3_pkg::WIN_N-1:0]                    mask,
	output logic [mf3_pkg::CH_W-1:0]                     med
);
	import mf3_pkg::*;

	logic [CNT_W-1:0]            n;
	logic [CNT_W-1:0]            half;
	logic [WIN_N-1:0][CNT_W-1:0] rank;

	// Rank every valid entry (ties broken by position) and pick rank n/2
	always_comb begin
		n = '0;
		for (int i = 0; i < WIN_N; i++)
			n = n + CNT_W'(mask[i]);
		half = n >> 1;

		for (int i = 0; i < WIN_N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WIN_N; j++) begin
				if (mask[j] && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))))
					rank[i] = rank[i] + CNT_W'(1);
			end
		end

		med = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (mask[i] && (rank[i] == half))
				med = med | vals[i];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mf3_checker.sv
`default_nettype none

module mf3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [mf3_pkg::ADDR_W-1:0]  paddr,
	input logic [mf3_pkg::DATA_W-1:0]  pwdata,
	input logic [mf3_pkg::DATA_W-1:0]  prdata,
	input logic                        pready,
	input logic                        pix_valid,
	input logic                        pix_stall,
	input logic [mf3_pkg::CH_W-1:0]    red_in,
	input logic [mf3_pkg::CH_W-1:0]    green_in,
	input logic [mf3_pkg::CH_W-1:0]    blue_in,
	input logic                        drain,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [mf3_pkg::CH_W-1:0]    median_red,
	input logic [mf3_pkg::CH_W-1:0]    median_green,
	input logic [mf3_pkg::CH_W-1:0]    median_blue,
	input logic                        frame_done
);
	import mf3_pkg::*;

	// Input backs up only when the full pipe is held by a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (res_valid && res_stall))
		else $error("input stalled without a stalled result");

	// No result straight out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(median_red)
			&& $stable(median_green) && $stable(median_blue) && $stable(frame_done)))
		else $error("stalled result changed");

	// A stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_stall) |=> (pix_valid && $stable(red_in)
			&& $stable(green_in) && $stable(blue_in) && $stable(drain)))
		else $error("stalled request changed");

	// Width written is read back
	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[IDX_LSB])
			##1 (psel && !pwrite && !paddr[IDX_LSB])
			|-> (prdata[FW_W-1:0] == $past(pwdata[FW_W-1:0])))
		else $error("frame width readback mismatch");

endmodule

bind median_filter_3x3_rgb mf3_checker u_mf3_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.pready       (pready),
	.pix_valid    (pix_valid),
	.pix_stall    (pix_stall),
	.red_in       (red_in),
	.green_in     (green_in),
	.blue_in      (blue_in),
	.drain        (drain),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.median_red   (median_red),
	.median_green (median_green),
	.median_blue  (median_blue),
	.frame_done   (frame_done)
);

`default_nettype wire

FILE: tb/sv/median_filter_3x3_rgb_checker.sv
`timescale 1ns / 1ps

module median_filter_3x3_rgb_checker
	import mf3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pix_valid,
	input  logic              pix_stall,
	input  logic [CH_W-1:0]   red_in,
	input  logic [CH_W-1:0]   green_in,
	input  logic [CH_W-1:0]   blue_in,
	input  logic              drain,
	input  logic              res_valid,
	input  logic              res_stall,
	input  logic [CH_W-1:0]   median_red,
	input  logic [CH_W-1:0]   median_green,
	input  logic [CH_W-1:0]   median_blue,
	input  logic              frame_done,
	output int                mismatch_count,
	output int                medians_pending
);

	localparam int WIDTH_AT_RESET  = 1024;
	localparam int HEIGHT_AT_RESET = 768;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t px;
		logic last;
	} median_t;

	rgb_t            upper_line [MAX_WIDTH];
	rgb_t            lower_line [MAX_WIDTH];
	rgb_t            win [WIN_N];
	int unsigned     in_col;
	int unsigned     in_row;
	logic [FW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	median_t         median_q [$];
	int              errors;

	// Per-channel median of the in-frame window entries around column mid.
	function automatic rgb_t neighbour_median(int mid, bit left_ok, bit right_ok,
			bit top_ok, bit bottom_ok);
		logic [CH_W-1:0] vals [N_CH][WIN_N];
		logic [CH_W-1:0] key;
		int              n;
		int              j;
		rgb_t            p;
		n = 0;
		for (int r = 0; r < WIN_SIDE; r++) begin
			if (r == 0 && !top_ok) continue;
			if (r == 2 && !bottom_ok) continue;
			for (int c = mid - 1; c <= mid + 1; c++) begin
				if (c < 0 || c > 2) continue;
				if (c == mid - 1 && !left_ok) continue;
				if (c == mid + 1 && !right_ok) continue;
				p = win[r * WIN_SIDE + c];
				vals[0][n] = p.red;
				vals[1][n] = p.green;
				vals[2][n] = p.blue;
				n++;
			end
		end
		if (n == 0)
			return '0;
		for (int ch = 0; ch < N_CH; ch++) begin
			for (int i = 1; i < n; i++) begin
				key = vals[ch][i];
				j = i - 1;
				while (j >= 0 && vals[ch][j] > key) begin
					vals[ch][j + 1] = vals[ch][j];
					j--;
				end
				vals[ch][j + 1] = key;
			end
		end
		return {vals[0][n / 2], vals[1][n / 2], vals[2][n / 2]};
	endfunction

	task automatic filter_pixel(rgb_t px, logic drn);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		rgb_t        pix;
		rgb_t        top;
		rgb_t        mid;
		median_t     res;
		bit          done;
		bit          emitted;
		w = (width_reg == '0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		h = (height_reg == '0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		col = in_col;
		row = in_row;
		done = 1'b0;
		emitted = 1'b0;
		res = '0;
		if (col >= w || row > h + 1) begin
			col = 0;
			row = 0;
		end
		pix = (drn || row >= h) ? '0 : px;
		top = upper_line[col];
		mid = lower_line[col];
		// row start closes the last column of the row two above
		if (col == 0 && row >= 2) begin
			res.px = neighbour_median(2, w >= 2, 1'b0, row - 2 >= 1, row - 1 < h);
			done = (row - 2 == h - 1);
			res.last = done;
			emitted = 1'b1;
		end
		for (int r = 0; r < WIN_SIDE; r++) begin
			win[r * WIN_SIDE]     = win[r * WIN_SIDE + 1];
			win[r * WIN_SIDE + 1] = win[r * WIN_SIDE + 2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = pix;
		upper_line[col] = mid;
		lower_line[col] = pix;
		if (col >= 1 && row >= 1) begin
			res.px = neighbour_median(1, col >= 2, 1'b1, row - 1 >= 1, row < h);
			res.last = 1'b0;
			emitted = 1'b1;
		end
		if (emitted)
			median_q.insert(median_q.size(), res);
		if (done) begin
			in_col = 0;
			in_row = 0;
		end else begin
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end
			in_col = col;
			in_row = row & ((1 << FH_W) - 1);
		end
	endtask

	task automatic compare_field(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		median_t want;
		if (!arst_n) begin
			width_reg = FW_W'(WIDTH_AT_RESET);
			height_reg = FH_W'(HEIGHT_AT_RESET);
			in_col = 0;
			in_row = 0;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			for (int i = 0; i < WIN_N; i++)
				win[i] = '0;
			median_q.delete();
			errors = 0;
			mismatch_count <= 0;
			medians_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]))
					REG_FRAME_WIDTH: begin
						width_reg = pwdata[FW_W-1:0];
						in_col = 0;
						in_row = 0;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = pwdata[FH_W-1:0];
						in_col = 0;
						in_row = 0;
					end
					default: ;
				endcase
			end
			// retire before predicting: no request yields a result at its own edge
			if (res_valid && !res_stall) begin
				if (median_q.size() == 0) begin
					$display("%0t: unexpected median r=%0d g=%0d b=%0d done=%0b", $time,
						median_red, median_green, median_blue, frame_done);
					errors++;
				end else begin
					want = median_q.pop_front();
					compare_field("median_red", want.px.red, median_red);
					compare_field("median_green", want.px.green, median_green);
					compare_field("median_blue", want.px.blue, median_blue);
					compare_field("frame_done", CH_W'(want.last), CH_W'(frame_done));
				end
			end
			if (pix_valid && !pix_stall)
				filter_pixel({red_in, green_in, blue_in}, drain);
			mismatch_count <= errors;
			medians_pending <= median_q.size();
		end
	end

endmodule

FILE: tb/sv/median_filter_3x3_rgb_tb.sv
`timescale 1ns / 1ps

module median_filter_3x3_rgb_tb;
	import mf3_pkg::*;

	// Run limit in clock cycles.
	localparam int LIMIT_CYCLES  = 400_000;
	// Cycles to let the pipeline empty out after the last expected median.
	localparam int SETTLE_CYCLES = 8;
	// Requests in the random part, split over three phases of idling and stalling.
	localparam int RANDOM_ITEMS  = 960;
	// Pixels sent into each frame of the register extremes before breaking off.
	localparam int EXTREME_ITEMS = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              pix_valid = 1'b0;
	logic              pix_stall;
	logic [CH_W-1:0]   red_in = '0;
	logic [CH_W-1:0]   green_in = '0;
	logic [CH_W-1:0]   blue_in = '0;
	logic              drain = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [CH_W-1:0]   median_red;
	logic [CH_W-1:0]   median_green;
	logic [CH_W-1:0]   median_blue;
	logic              frame_done;

	int                mismatch_count;
	int                medians_pending;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int unsigned       cycle_count = 0;
	int unsigned       requests_sent = 0;
	// Frame geometry as the block uses it, after clamping of the register values
	int unsigned       frame_w = 1024;
	int unsigned       frame_h = 768;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	median_filter_3x3_rgb dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.drain        (drain),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.median_red   (median_red),
		.median_green (median_green),
		.median_blue  (median_blue),
		.frame_done   (frame_done)
	);

	median_filter_3x3_rgb_checker median_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pix_valid       (pix_valid),
		.pix_stall       (pix_stall),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.drain           (drain),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.median_red      (median_red),
		.median_green    (median_green),
		.median_blue     (median_blue),
		.frame_done      (frame_done),
		.mismatch_count  (mismatch_count),
		.medians_pending (medians_pending)
	);

	// Receiver: stall the result channel at random, one fresh decision per cycle.
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: give up if the run hangs anywhere.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Pixel with a bias toward ties and extreme channel values now and then.
	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] p;
		p = PIX_W'($urandom);
		if ($urandom_range(3) == 0)
			p = p & {N_CH{8'h81}};
		return p;
	endfunction

	// Offer one request; hold the payload until the block takes it.
	task automatic send_request(logic [PIX_W-1:0] px, logic drn);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in    <= px[3*CH_W-1:2*CH_W];
		green_in  <= px[2*CH_W-1:CH_W];
		blue_in   <= px[CH_W-1:0];
		drain     <= drn;
		do @(posedge clk); while (pix_stall);
		requests_sent++;
	endtask

	// Drop valid and wait until every expected median is back, then let the
	// pipeline run dry so that requests with no result have left it too.
	task automatic settle();
		pix_valid <= 1'b0;
		do @(posedge clk); while (medians_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access until pready.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, {IDX_LSB{1'b0}}};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write both geometry registers (each write restarts the frame). Bits above
	// the field get random junk half the time; the block must ignore them.
	task automatic set_geometry(logic [FW_W-1:0] w, logic [FH_W-1:0] h);
		logic [DATA_W-1:0] junk;
		junk = $urandom_range(1) ? DATA_W'($urandom) : '0;
		write_reg(REG_FRAME_WIDTH, {junk[DATA_W-1:FW_W], w});
		junk = $urandom_range(1) ? DATA_W'($urandom) : '0;
		write_reg(REG_FRAME_HEIGHT, {junk[DATA_W-1:FH_W], h});
		frame_w = (w == '0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		frame_h = (h == '0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
	endtask

	// Send the first stop_at pixels of a frame; a full frame also gets its
	// width + 1 flush requests, some of them carrying ignored pixel data.
	task automatic send_frame(int unsigned stop_at);
		int unsigned npix;
		npix = frame_w * frame_h;
		for (int unsigned i = 0; i < npix && i < stop_at; i++)
			send_request(random_pixel(), $urandom_range(99) < 8);
		if (stop_at >= npix) begin
			for (int unsigned i = 0; i <= frame_w; i++)
				send_request(random_pixel(), $urandom_range(99) < 75);
		end
	endtask

	initial begin
		int unsigned     target;
		int unsigned     npix;
		logic [FW_W-1:0] w;
		logic [FH_W-1:0] h;
		bit              aborted;

		// Hold reset at the start, once.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Abort a 3x3 frame part way through, then restart with a new geometry.
		set_geometry(11'd3, 13'd3);
		send_frame(4);
		settle();

		// Two-pixel single row: every window is cut at top and bottom.
		set_geometry(11'd2, 13'd1);
		send_request(24'h000000, 1'b0);
		send_request(24'hFFFFFF, 1'b0);
		send_request(24'h000000, 1'b1);
		send_request(24'hFFFFFF, 1'b1);
		send_request(24'h00FF00, 1'b1);
		settle();

		// Full 3x3 frame with extreme channels, a drain inside the frame, and
		// pixels offered after the last one (the block treats them as drains).
		set_geometry(11'd3, 13'd3);
		send_request(24'h000000, 1'b0);
		send_request(24'hFFFFFF, 1'b0);
		send_request(24'hFF00FF, 1'b0);
		send_request(24'h00FF00, 1'b0);
		send_request(24'h123456, 1'b1);
		send_request(24'hFFFF00, 1'b0);
		send_request(24'h0000FF, 1'b0);
		send_request(24'h800180, 1'b0);
		send_request(24'hFFFFFF, 1'b0);
		send_request(24'hA5A5A5, 1'b0);
		send_request(24'h5A5A5A, 1'b0);
		send_request(24'h000000, 1'b1);
		send_request(24'hFFFFFF, 1'b1);
		// Pause the sender until every median is back.
		settle();

		// Random frames in three phases: receiver-heavy stalling, sender-heavy
		// idling, then none at all. Geometry changes between most frames;
		// some frames are broken off early and restarted by a register write.
		aborted = 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 33;
					recv_stall_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			target = requests_sent + RANDOM_ITEMS / 3;
			while (requests_sent < target) begin
				if (aborted || $urandom_range(9) < 7) begin
					w = ($urandom_range(7) == 0) ? '0 : FW_W'($urandom_range(12, 1));
					h = ($urandom_range(7) == 0) ? '0 : FH_W'($urandom_range(6, 1));
					settle();
					set_geometry(w, h);
				end
				npix = frame_w * frame_h;
				aborted = ($urandom_range(9) == 0);
				send_frame(aborted ? $urandom_range(npix - 1) : npix);
			end
		end

		// Extremes of the registers, including values the block clamps; each frame
		// is broken off early, and all but the last are restarted by the next register write.
		settle();
		set_geometry(11'd1024, 13'd3);
		send_frame(EXTREME_ITEMS);
		settle();
		set_geometry(11'h7FF, 13'd0);
		send_frame(EXTREME_ITEMS);
		settle();
		set_geometry(11'd0, 13'h1FFF);
		send_frame(EXTREME_ITEMS);
		settle();
		set_geometry(11'd1, 13'd4096);
		send_frame(EXTREME_ITEMS);

		settle();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
